>>> hdl/bad_pkg.sv
// Shared types and constants of the bounded array deque.
package bad_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [2:0] REQ_CLEAR      = 3'd6;
  localparam logic [2:0] REQ_STATUS     = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_END   = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         occupancy;
    logic               is_empty;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic load;
  } ctl_cmd_t;

endpackage

>>> hdl/bad_ctrl.sv
// Controller state machine of the bounded array deque.
module bad_ctrl import bad_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.start = 1'b0;
    cmd.load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/bad_dpath.sv
// Datapath of the bounded array deque: indices, entry memory and result word.
module bad_dpath import bad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  in_word_t  in_data,
  output out_word_t out_data
);

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data_r;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic             hit_r, hit_nxt;
  logic [1:0]       stat_r, stat_nxt;
  out_word_t        out_data_r;

  logic             wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic             empty;
  logic [IDX_W-1:0] front_dec, back_dec, count, occ;
  logic [IDX_W:0]   half, front_sum;

  always_comb begin
    empty     = (front_r == back_r);
    front_dec = front_r - 1'b1;
    back_dec  = back_r - 1'b1;
    count     = back_r - front_r;
    half      = ({1'b0, count} + 1'b1) >> 1;
    front_sum = {1'b0, front_r} + half;

    front_nxt = front_r;
    back_nxt  = back_r;
    hit_nxt   = 1'b0;
    stat_nxt  = STAT_OK;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = front_r[ADDR_W-1:0];
    rd_addr   = front_r[ADDR_W-1:0];

    case (in_data.req_type)
      REQ_PUSH_FRONT: begin
        if (front_r != '0) begin
          front_nxt = front_dec;
          wr_en     = 1'b1;
          wr_addr   = front_dec[ADDR_W-1:0];
        end else begin
          stat_nxt = STAT_END;
        end
      end
      REQ_PUSH_BACK: begin
        if (back_r != IDX_W'(DEPTH)) begin
          back_nxt = back_r + 1'b1;
          wr_en    = 1'b1;
          wr_addr  = back_r[ADDR_W-1:0];
        end else begin
          stat_nxt = STAT_END;
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (empty) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          rd_en   = 1'b1;
          hit_nxt = 1'b1;
          rd_addr = front_r[ADDR_W-1:0];
          if (in_data.req_type == REQ_POP_FRONT) begin
            front_nxt = front_r + 1'b1;
          end
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (empty) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          rd_en   = 1'b1;
          hit_nxt = 1'b1;
          rd_addr = back_dec[ADDR_W-1:0];
          if (in_data.req_type == REQ_POP_BACK) begin
            back_nxt = back_dec;
          end
        end
      end
      REQ_CLEAR: begin
        front_nxt = front_sum[IDX_W-1:0];
        back_nxt  = front_sum[IDX_W-1:0];
      end
      default: begin
      end
    endcase

    if (!cmd.start) begin
      front_nxt = front_r;
      back_nxt  = back_r;
      hit_nxt   = hit_r;
      stat_nxt  = stat_r;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
    end
    occ = back_r - front_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= IDX_W'(DEPTH / 2);
      back_r  <= IDX_W'(DEPTH / 2);
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    stat_r <= stat_nxt;
    if (cmd.load) begin
      out_data_r.read_value <= hit_r ? rd_data_r : '0;
      out_data_r.status     <= stat_r;
      out_data_r.occupancy  <= 7'(occ);
      out_data_r.is_empty   <= (front_r == back_r);
    end
  end

  assign out_data = out_data_r;

endmodule

>>> hdl/bounded_array_deque_top.sv
// Top level of the bounded array deque.
// Each request word passes through the ST_IDLE and ST_FETCH states: in ST_IDLE the
// indices are updated and the entry memory is written or read, in ST_FETCH the registered
// read data and the status are loaded into the output register; the request after it is
// taken once that load has happened, so a stalled result holds the block in ST_FETCH.
// The 64-entry memory has one write and one read port and needs no clearing pass.
module bounded_array_deque_top import bad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  ctl_cmd_t cmd;

  bad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  bad_dpath u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .out_data(out_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("a second word was taken while one was in flight");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.occupancy <= 7'(DEPTH)
                  && out_data.is_empty == (out_data.occupancy == 7'd0))
    else $error("occupancy and empty flag disagree");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.read_value == '0)
    else $error("failed request returned a nonzero word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == STAT_OK || out_data.status == STAT_EMPTY
                  || out_data.status == STAT_END)
    else $error("undefined status code");

endmodule
